[rtl/afa_pkg.sv]
// Shared types, codes and helper functions for the ALE frame assembler.
// Depends on nothing; every other file in rtl/ imports it.
`timescale 1ns / 1ps

package afa_pkg;

  // Default buffer depth and configuration reset value.
  localparam int MAX_CONTENT_DEF = 16;
  localparam logic [31:0] GAP_TIMEOUT_RESET = 32'd5000;

  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [15:0] WORD_COUNT_MAX = 16'hFFFF;

  // Configuration register index (selected by paddr[2]).
  localparam logic REG_GAP_TIMEOUT = 1'b0;

  // Preamble codes of a decoded ALE word.
  typedef enum logic [2:0] {
    PRE_DATA = 3'd0,
    PRE_THRU = 3'd1,
    PRE_TO   = 3'd2,
    PRE_TWAS = 3'd3,
    PRE_FROM = 3'd4,
    PRE_TIS  = 3'd5,
    PRE_CMD  = 3'd6,
    PRE_REP  = 3'd7
  } preamble_t;

  // Call kind codes reported in the summary beat.
  localparam logic [1:0] KIND_INDIVIDUAL = 2'd0;
  localparam logic [1:0] KIND_SOUNDING   = 2'd1;
  localparam logic [1:0] KIND_AMD        = 2'd2;
  localparam logic [1:0] KIND_UNKNOWN    = 2'd3;

  // Bit positions in the seen-preamble flags.
  localparam int SEEN_TO   = 0;
  localparam int SEEN_TIS  = 1;
  localparam int SEEN_FROM = 2;
  localparam int SEEN_TWAS = 3;
  localparam int SEEN_CMD  = 4;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_PICK,
    ST_READ,
    ST_LOAD,
    ST_SUMMARY
  } afa_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;        // capture the input beat
    logic update;       // apply the captured word to the frame state
    logic rd_issue;     // read the buffer entry at the read pointer
    logic load_content; // move the read entry into the output register
    logic load_summary; // load the summary beat and clear the frame
  } afa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic conclude;     // captured word is a valid TIS or TWAS
    logic more;         // buffered entries remain to be sent
    logic slot_free;    // output register can take a beat this cycle
  } afa_status_t;

  // Call classification from the seen-preamble flags; order of tests matters.
  function automatic logic [1:0] call_kind_of(input logic [4:0] f);
    logic to, tis, from, twas, cmd;
    logic [1:0] k;
    to   = f[SEEN_TO];
    tis  = f[SEEN_TIS];
    from = f[SEEN_FROM];
    twas = f[SEEN_TWAS];
    cmd  = f[SEEN_CMD];
    if (tis && !to && !from && !twas) begin
      k = KIND_SOUNDING;
    end else if (to && (tis || from) && cmd) begin
      k = KIND_AMD;
    end else if (to && (tis || from) && !twas) begin
      k = KIND_INDIVIDUAL;
    end else begin
      k = KIND_UNKNOWN;
    end
    return k;
  endfunction

  // Number of characters left after trailing spaces are trimmed.
  function automatic logic [1:0] trim_len(input logic [23:0] c);
    logic [1:0] n;
    if (c[7:0] != SPACE_CHAR) begin
      n = 2'd3;
    end else if (c[15:8] != SPACE_CHAR) begin
      n = 2'd2;
    end else if (c[23:16] != SPACE_CHAR) begin
      n = 2'd1;
    end else begin
      n = 2'd0;
    end
    return n;
  endfunction

  // Characters kept for a given length, unused low bytes zero.
  function automatic logic [23:0] trim_chars(input logic [23:0] c, input logic [1:0] n);
    logic [23:0] k;
    unique case (n)
      2'd3:    k = c;
      2'd2:    k = {c[23:8], 8'h00};
      2'd1:    k = {c[23:16], 16'h0000};
      default: k = 24'h000000;
    endcase
    return k;
  endfunction

endpackage

[rtl/ale_frame_assembler_unit.sv]
// Top level of the ALE frame assembler: configuration port, controller and
// datapath. Depends on afa_pkg, afa_ctrl and afa_datapath.
`timescale 1ns / 1ps

//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+-----------------------------------------
//  input    | in        | in_valid/in_stall  | word_ok, preamble, chars, stamp_ms
//  output   | out       | out_valid/out_stall| is_summary .. last (eight fields)
//  config   | in/out    | psel/penable/pready| paddr, pwdata, prdata (gap_timeout_ms)
//
// A word that does not conclude a frame is captured, then applied to the frame.
// A concluding word then sends the buffered content words (at most MAX_CONTENT),
// each through a pick, a registered buffer read and a load into the single
// output register, and last the summary beat.
// Reset is synchronous; no clearing pass is run, the buffer needs none.
// Output stalls hold the output register and, during emission, the controller.

module ale_frame_assembler_unit #(
  parameter int MAX_CONTENT = afa_pkg::MAX_CONTENT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        word_ok,
  input  logic [2:0]  preamble,
  input  logic [23:0] chars,
  input  logic [31:0] stamp_ms,
  // Output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_summary,
  output logic [23:0] content_chars,
  output logic [1:0]  content_len,
  output logic [1:0]  call_kind,
  output logic [31:0] span_ms,
  output logic [15:0] word_total,
  output logic        overflowed,
  output logic        last,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import afa_pkg::*;

  logic [31:0] gap_timeout_ms;
  afa_cmd_t    cmd;
  afa_status_t status;

  // Configuration register; the one register sits at byte address 0.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_timeout_ms <= GAP_TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_GAP_TIMEOUT)) begin
      gap_timeout_ms <= pwdata;
    end
  end

  assign prdata = (paddr[2] == REG_GAP_TIMEOUT) ? gap_timeout_ms : 32'd0;

  afa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  afa_datapath #(
    .MAX_CONTENT (MAX_CONTENT)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .gap_timeout_ms (gap_timeout_ms),
    .cmd            (cmd),
    .status         (status),
    .word_ok        (word_ok),
    .preamble       (preamble),
    .chars          (chars),
    .stamp_ms       (stamp_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .is_summary     (is_summary),
    .content_chars  (content_chars),
    .content_len    (content_len),
    .call_kind      (call_kind),
    .span_ms        (span_ms),
    .word_total     (word_total),
    .overflowed     (overflowed),
    .last           (last)
  );

  // The input is always stalled in the cycle after a word is accepted.
  a_accept_then_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted on back-to-back cycles");

  // The final beat of a run is the summary and nothing else.
  a_last_is_summary: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == is_summary))
    else $error("last and is_summary disagree");

  // Content beats never carry an empty word.
  a_content_nonempty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_summary) |-> (content_len != 2'd0))
    else $error("empty content word emitted");

endmodule

[rtl/afa_ctrl.sv]
// Controller state machine of the ALE frame assembler.
// Depends on afa_pkg; drives afa_datapath through command and status structs.
`timescale 1ns / 1ps

module afa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  afa_pkg::afa_status_t status,
  output afa_pkg::afa_cmd_t    cmd
);
  import afa_pkg::*;

  afa_state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = status.conclude ? ST_PICK : ST_IDLE;
      end
      ST_PICK: begin
        state_next = status.more ? ST_READ : ST_SUMMARY;
      end
      ST_READ: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (status.slot_free) state_next = ST_PICK;
      end
      ST_SUMMARY: begin
        if (status.slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output logic.
  always_comb begin
    cmd          = '0;
    in_stall     = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.latch = in_valid;
      end
      ST_UPDATE:  cmd.update = 1'b1;
      ST_PICK:    cmd = '0;
      ST_READ:    cmd.rd_issue = 1'b1;
      ST_LOAD:    cmd.load_content = status.slot_free;
      ST_SUMMARY: cmd.load_summary = status.slot_free;
      default:    cmd = '0;
    endcase
  end

endmodule

[rtl/afa_datapath.sv]
// Datapath of the ALE frame assembler: input capture, frame state, content
// buffer memory and output register. Depends on afa_pkg; commanded by afa_ctrl.
`timescale 1ns / 1ps

module afa_datapath #(
  parameter int MAX_CONTENT = afa_pkg::MAX_CONTENT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [31:0]          gap_timeout_ms,
  input  afa_pkg::afa_cmd_t    cmd,
  output afa_pkg::afa_status_t status,
  input  logic                 word_ok,
  input  logic [2:0]           preamble,
  input  logic [23:0]          chars,
  input  logic [31:0]          stamp_ms,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 is_summary,
  output logic [23:0]          content_chars,
  output logic [1:0]           content_len,
  output logic [1:0]           call_kind,
  output logic [31:0]          span_ms,
  output logic [15:0]          word_total,
  output logic                 overflowed,
  output logic                 last
);
  import afa_pkg::*;

  localparam int CNT_W = $clog2(MAX_CONTENT + 1);
  localparam int IDX_W = (MAX_CONTENT > 1) ? $clog2(MAX_CONTENT) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CONTENT);

  // Captured input beat.
  logic        ok_r;
  preamble_t   pre_r;
  logic [23:0] chars_r;
  logic [31:0] stamp_r;

  // Frame state.
  logic             frame_open;
  logic [31:0]      first_time;
  logic [31:0]      prev_time;
  logic [4:0]       seen_flags;
  logic             after_cmd;
  logic [CNT_W-1:0] content_count;
  logic [15:0]      word_counter;
  logic             drop_flag;
  logic [CNT_W-1:0] rd_ptr;

  // Content buffer: {length, characters} per entry.
  logic [25:0] mem [MAX_CONTENT];
  logic [25:0] rd_data;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      ok_r    <= word_ok;
      pre_r   <= preamble_t'(preamble);
      chars_r <= chars;
      stamp_r <= stamp_ms;
    end
  end

  // Word update: timeout check, then fold the word into the frame.
  logic             timed_out;
  logic             open_eff;
  logic [4:0]       seen_base;
  logic             after_base;
  logic [CNT_W-1:0] count_base;
  logic [15:0]      wc_base;
  logic             drop_base;
  logic [4:0]       seen_bit;
  logic             is_content;
  logic [1:0]       kept_len;
  logic [23:0]      kept_chars;
  logic             do_buffer;
  logic             has_room;

  always_comb begin
    timed_out  = frame_open && (stamp_r >= prev_time) &&
                 ((stamp_r - prev_time) > gap_timeout_ms);
    open_eff   = frame_open && !timed_out;
    seen_base  = open_eff ? seen_flags : 5'b0;
    after_base = open_eff ? after_cmd : 1'b0;
    count_base = open_eff ? content_count : '0;
    wc_base    = open_eff ? word_counter : 16'd0;
    drop_base  = open_eff ? drop_flag : 1'b0;

    seen_bit = 5'b0;
    unique case (pre_r)
      PRE_TO:   seen_bit[SEEN_TO]   = 1'b1;
      PRE_TIS:  seen_bit[SEEN_TIS]  = 1'b1;
      PRE_FROM: seen_bit[SEEN_FROM] = 1'b1;
      PRE_TWAS: seen_bit[SEEN_TWAS] = 1'b1;
      PRE_CMD:  seen_bit[SEEN_CMD]  = 1'b1;
      default:  seen_bit = 5'b0;
    endcase

    is_content = (pre_r == PRE_CMD) ||
                 (((pre_r == PRE_DATA) || (pre_r == PRE_REP)) && after_base);
    kept_len   = trim_len(chars_r);
    kept_chars = trim_chars(chars_r, kept_len);
    do_buffer  = is_content && (kept_len != 2'd0);
    has_room   = count_base < CNT_MAX;
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open    <= 1'b0;
      first_time    <= '0;
      prev_time     <= '0;
      seen_flags    <= '0;
      after_cmd     <= 1'b0;
      content_count <= '0;
      word_counter  <= '0;
      drop_flag     <= 1'b0;
      rd_ptr        <= '0;
    end else if (cmd.update && ok_r) begin
      frame_open   <= 1'b1;
      first_time   <= open_eff ? first_time : stamp_r;
      prev_time    <= stamp_r;
      seen_flags   <= seen_base | seen_bit;
      after_cmd    <= after_base || (pre_r == PRE_CMD);
      word_counter <= (wc_base == WORD_COUNT_MAX) ? wc_base : wc_base + 16'd1;
      if (do_buffer && has_room) begin
        content_count <= count_base + CNT_W'(1);
      end else begin
        content_count <= count_base;
      end
      drop_flag <= drop_base || (do_buffer && !has_room);
      rd_ptr    <= '0;
    end else if (cmd.load_content) begin
      rd_ptr <= rd_ptr + CNT_W'(1);
    end else if (cmd.load_summary) begin
      frame_open    <= 1'b0;
      first_time    <= '0;
      prev_time     <= '0;
      seen_flags    <= '0;
      after_cmd     <= 1'b0;
      content_count <= '0;
      word_counter  <= '0;
      drop_flag     <= 1'b0;
      rd_ptr        <= '0;
    end
  end

  // Buffer write during the update, registered read during emission.
  always_ff @(posedge clk) begin
    if (cmd.update && ok_r && do_buffer && has_room) begin
      mem[count_base[IDX_W-1:0]] <= {kept_len, kept_chars};
    end
    if (cmd.rd_issue) begin
      rd_data <= mem[rd_ptr[IDX_W-1:0]];
    end
  end

  // Output register; a beat leaves when it is not stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_content || cmd.load_summary) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_content) begin
      is_summary    <= 1'b0;
      content_chars <= rd_data[23:0];
      content_len   <= rd_data[25:24];
      call_kind     <= 2'd0;
      span_ms       <= 32'd0;
      word_total    <= 16'd0;
      overflowed    <= 1'b0;
      last          <= 1'b0;
    end else if (cmd.load_summary) begin
      is_summary    <= 1'b1;
      content_chars <= 24'd0;
      content_len   <= 2'd0;
      call_kind     <= call_kind_of(seen_flags);
      span_ms       <= stamp_r - first_time;
      word_total    <= word_counter;
      overflowed    <= drop_flag;
      last          <= 1'b1;
    end
  end

  // Status back to the controller.
  always_comb begin
    status.conclude  = ok_r && ((pre_r == PRE_TIS) || (pre_r == PRE_TWAS));
    status.more      = rd_ptr < content_count;
    status.slot_free = !out_valid || !out_stall;
  end

endmodule

[tb/tb_ale_frame_assembler_unit.sv]
// Self-checking testbench for the ALE frame assembler: directed and random ALE
// frames with a scoreboard class that predicts every output beat.
// Depends on rtl/afa_pkg.sv and rtl/ale_frame_assembler_unit.sv.
`timescale 1ns / 1ps

module tb_ale_frame_assembler_unit;
  import afa_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 220;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [2:0] ADDR_GAP_TIMEOUT = {REG_GAP_TIMEOUT, 2'b00};

  // One output beat, field for field as the block presents it.
  typedef struct packed {
    logic        is_summary;
    logic [23:0] content_chars;
    logic [1:0]  content_len;
    logic [1:0]  call_kind;
    logic [31:0] span_ms;
    logic [15:0] word_total;
    logic        overflowed;
    logic        last;
  } frame_beat_t;

  // Tracks the open frame from accepted words and holds the beats it must emit.
  class frame_scoreboard;
    logic [31:0] gap_limit;
    bit          frame_live;
    logic [31:0] start_ms;
    logic [31:0] prev_ms;
    logic [4:0]  seen;
    bit          past_cmd;
    logic [23:0] held_chars [MAX_CONTENT_DEF];
    logic [1:0]  held_len [MAX_CONTENT_DEF];
    int          held_count;
    logic [15:0] word_count;
    bit          lost_words;
    frame_beat_t expected_beats[$];
    int          failures;
    int          reported;

    function new();
      gap_limit = GAP_TIMEOUT_RESET;
      prev_ms = '0;
      failures = 0;
      reported = 0;
      drop_frame();
    endfunction

    function void drop_frame();
      frame_live = 0;
      start_ms = '0;
      seen = '0;
      past_cmd = 0;
      held_count = 0;
      word_count = '0;
      lost_words = 0;
    endfunction

    // Trailing spaces are trimmed; a word of spaces only is not kept.
    function void hold_word(logic [23:0] c);
      int n;
      n = 3;
      while (n > 0 && c[8*(3-n) +: 8] == SPACE_CHAR) n--;
      if (n == 0) return;
      if (held_count < MAX_CONTENT_DEF) begin
        held_chars[held_count] = c & (24'hFFFFFF << (8 * (3 - n)));
        held_len[held_count] = 2'(n);
        held_count++;
      end else begin
        lost_words = 1;
      end
    endfunction

    // Tests are ordered: sounding wins over AMD, AMD over individual.
    function logic [1:0] classify(logic [4:0] f);
      if (f[SEEN_TIS] && !f[SEEN_TO] && !f[SEEN_FROM] && !f[SEEN_TWAS]) return KIND_SOUNDING;
      if (f[SEEN_TO] && (f[SEEN_TIS] || f[SEEN_FROM]) && f[SEEN_CMD]) return KIND_AMD;
      if (f[SEEN_TO] && (f[SEEN_TIS] || f[SEEN_FROM]) && !f[SEEN_TWAS]) return KIND_INDIVIDUAL;
      return KIND_UNKNOWN;
    endfunction

    function void note_word(logic ok, preamble_t pre, logic [23:0] c, logic [31:0] now);
      frame_beat_t b;
      int i;
      if (!ok) return;
      // A backwards stamp never times out; an equal gap is still allowed.
      if (frame_live && now >= prev_ms && (now - prev_ms) > gap_limit) drop_frame();
      if (!frame_live) begin
        start_ms = now;
        frame_live = 1;
      end
      if (word_count != WORD_COUNT_MAX) word_count++;
      prev_ms = now;

      case (pre)
        PRE_TO:   seen[SEEN_TO] = 1'b1;
        PRE_TIS:  seen[SEEN_TIS] = 1'b1;
        PRE_FROM: seen[SEEN_FROM] = 1'b1;
        PRE_TWAS: seen[SEEN_TWAS] = 1'b1;
        PRE_CMD:  seen[SEEN_CMD] = 1'b1;
        default: ;
      endcase

      if (pre == PRE_CMD) begin
        past_cmd = 1;
        hold_word(c);
      end else if ((pre == PRE_DATA || pre == PRE_REP) && past_cmd) begin
        hold_word(c);
      end

      if (pre != PRE_TIS && pre != PRE_TWAS) return;

      // Concluding word: content beats in order, then the summary.
      for (i = 0; i < held_count; i++) begin
        b = '0;
        b.content_chars = held_chars[i];
        b.content_len = held_len[i];
        expected_beats.insert(expected_beats.size(), b);
      end
      b = '0;
      b.is_summary = 1'b1;
      b.call_kind = classify(seen);
      b.span_ms = now - start_ms;
      b.word_total = word_count;
      b.overflowed = lost_words;
      b.last = 1'b1;
      expected_beats.insert(expected_beats.size(), b);
      drop_frame();
      prev_ms = '0;
    endfunction

    function void check_beat(frame_beat_t got);
      frame_beat_t want;
      if (expected_beats.size() == 0) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("unexpected beat: sum=%0b chars=%06h len=%0d kind=%0d dur=%08h total=%0d ovf=%0b last=%0b",
                   got.is_summary, got.content_chars, got.content_len, got.call_kind,
                   got.span_ms, got.word_total, got.overflowed, got.last);
        end
        return;
      end
      want = expected_beats.pop_front();
      if (got !== want) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("mismatch expected: sum=%0b chars=%06h len=%0d kind=%0d dur=%08h total=%0d ovf=%0b last=%0b",
                   want.is_summary, want.content_chars, want.content_len, want.call_kind,
                   want.span_ms, want.word_total, want.overflowed, want.last);
          $display("         actual:   sum=%0b chars=%06h len=%0d kind=%0d dur=%08h total=%0d ovf=%0b last=%0b",
                   got.is_summary, got.content_chars, got.content_len, got.call_kind,
                   got.span_ms, got.word_total, got.overflowed, got.last);
        end
      end
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        word_ok = 1'b0;
  logic [2:0]  preamble = PRE_DATA;
  logic [23:0] chars = '0;
  logic [31:0] stamp_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        is_summary;
  logic [23:0] content_chars;
  logic [1:0]  content_len;
  logic [1:0]  call_kind;
  logic [31:0] span_ms;
  logic [15:0] word_total;
  logic        overflowed;
  logic        last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  frame_scoreboard sb;
  int          cycles = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  logic [31:0] stamp_now = '0;
  int          stall_mode = 0;
  int          mode_left = 0;
  int          run_left = 0;

  ale_frame_assembler_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .word_ok(word_ok), .preamble(preamble), .chars(chars), .stamp_ms(stamp_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .is_summary(is_summary), .content_chars(content_chars), .content_len(content_len),
    .call_kind(call_kind), .span_ms(span_ms), .word_total(word_total),
    .overflowed(overflowed), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Output side: check each accepted beat, then pick the next stall value.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_beat({is_summary, content_chars, content_len, call_kind,
                     span_ms, word_total, overflowed, last});
    end
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left <= $urandom_range(64, 512);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 4) < 3);
      default: begin
        // Long runs of stall and flow.
        if (run_left == 0) begin
          out_stall <= ~out_stall;
          run_left <= $urandom_range(1, 20);
        end else begin
          run_left <= run_left - 1;
        end
      end
    endcase
  end

  // Random characters, often with trailing or inner spaces.
  function automatic logic [23:0] pick_chars();
    logic [23:0] c;
    int n;
    case ($urandom_range(0, 7))
      0: c = {SPACE_CHAR, SPACE_CHAR, SPACE_CHAR};
      1: c = 24'($urandom);
      default: begin
        for (int i = 0; i < 3; i++) begin
          c[8*i +: 8] = ($urandom_range(0, 4) == 0) ? SPACE_CHAR : 8'($urandom);
        end
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) c[8*i +: 8] = SPACE_CHAR;
      end
    endcase
    return c;
  endfunction

  // Offer one input beat and hold it until accepted; gaps follow bursts.
  task automatic send_word(input logic ok, input preamble_t pre, input logic [23:0] c,
                           input logic [31:0] stamp);
    int gap;
    in_valid <= 1'b1;
    word_ok <= ok;
    preamble <= pre;
    chars <= c;
    stamp_ms <= stamp;
    do @(posedge clk); while (in_stall);
    sb.note_word(ok, pre, c, stamp);
    if (ok) items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Valid word of a frame, with the stamp moved on; now and then a dud word first.
  task automatic put_word(input preamble_t pre, input logic [23:0] c);
    if ($urandom_range(0, 15) == 0) begin
      send_word(1'b0, preamble_t'($urandom_range(0, 7)), 24'($urandom), $urandom);
    end
    case ($urandom_range(0, 19))
      0: stamp_now = stamp_now + sb.gap_limit;
      1: stamp_now = stamp_now + sb.gap_limit + 32'd1;
      2: stamp_now = stamp_now - $urandom_range(1, 100000);
      3: stamp_now = $urandom;
      default: stamp_now = stamp_now + $urandom_range(0, (sb.gap_limit < 3000) ? sb.gap_limit : 3000);
    endcase
    send_word(1'b1, pre, c, stamp_now);
  endtask

  // Drop valid and wait until every expected beat has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, then access until pready.
  task automatic apb_access(input logic wr, input logic [31:0] d, output logic [31:0] rd);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ADDR_GAP_TIMEOUT;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_gap_timeout(input logic [31:0] want);
    logic [31:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd !== want) begin
      sb.failures++;
      $display("gap_timeout_ms reads %08h, expected %08h", rd, want);
    end
  endtask

  task automatic set_gap_timeout(input logic [31:0] v);
    logic [31:0] rd;
    wait_drained();
    apb_access(1'b1, v, rd);
    sb.gap_limit = v;
    check_gap_timeout(v);
  endtask

  // Mostly well-formed calls with random content; some noise and broken frames.
  task automatic run_random_frame();
    int n;
    int k;
    preamble_t pre;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) send_word(1'($urandom), preamble_t'($urandom_range(0, 7)), pick_chars(), $urandom);
      return;
    end
    if ($urandom_range(0, 9) == 0) wait_drained();
    // Address part, sometimes left out.
    if ($urandom_range(0, 7) != 0) begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        case ($urandom_range(0, 5))
          0, 1: pre = PRE_TO;
          2:    pre = PRE_FROM;
          3:    pre = PRE_THRU;
          4:    pre = PRE_DATA;
          default: pre = PRE_REP;
        endcase
        put_word(pre, pick_chars());
      end
    end
    // Message part: a CMD word and its DATA and REP words, sometimes enough to overflow.
    if ($urandom_range(0, 3) != 0) begin
      put_word(PRE_CMD, pick_chars());
      k = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 20) : $urandom_range(0, 6);
      repeat (k) put_word($urandom_range(0, 1) ? PRE_DATA : PRE_REP, pick_chars());
    end
    // Conclusion, missing now and then.
    if ($urandom_range(0, 7) != 0) put_word($urandom_range(0, 1) ? PRE_TIS : PRE_TWAS, pick_chars());
  endtask

  initial begin
    logic [31:0] phase_gap [5];
    int target;
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    check_gap_timeout(GAP_TIMEOUT_RESET);

    // Directed: field extremes, each call kind, dud word, timeout edges, time reversal.
    send_word(1'b1, PRE_TIS, 24'hFFFFFF, 32'hFFFFFFFF);            // sounding
    send_word(1'b1, PRE_TO, 24'h000000, 32'd0);
    send_word(1'b1, PRE_TIS, 24'h58595A, 32'd10);                  // individual
    send_word(1'b1, PRE_TO, 24'h4B3120, 32'd1000);
    send_word(1'b1, PRE_DATA, 24'h505245, 32'd1001);               // before CMD, not kept
    send_word(1'b1, PRE_CMD, 24'h484920, 32'd1002);                // "HI "
    send_word(1'b1, PRE_DATA, 24'h202058, 32'd1003);               // "  X"
    send_word(1'b1, PRE_REP, 24'h412020, 32'd1004);                // "A  "
    send_word(1'b1, PRE_DATA, 24'h202020, 32'd1005);               // all spaces
    send_word(1'b1, PRE_THRU, 24'h414243, 32'd1006);
    send_word(1'b1, PRE_FROM, 24'h444546, 32'd1007);
    send_word(1'b1, PRE_TIS, 24'h474849, 32'd1008);                // AMD
    send_word(1'b0, PRE_TWAS, 24'h123456, 32'd1500);               // ignored
    send_word(1'b1, PRE_TWAS, 24'h313233, 32'd2000);               // unknown
    send_word(1'b1, PRE_TO, 24'h414141, 32'd3000);
    send_word(1'b1, PRE_TO, 24'h424242, 32'd8000);                 // gap equal to limit
    send_word(1'b1, PRE_TIS, 24'h434343, 32'd13000);
    send_word(1'b1, PRE_TO, 24'h414141, 32'd20000);
    send_word(1'b1, PRE_FROM, 24'h424242, 32'd25001);              // gap one past limit
    send_word(1'b1, PRE_TWAS, 24'h434343, 32'd25002);
    send_word(1'b1, PRE_TO, 24'h414141, 32'd900000);
    send_word(1'b1, PRE_FROM, 24'h424242, 32'd800000);             // stamp went backwards
    send_word(1'b1, PRE_TWAS, 24'h434343, 32'd800500);

    // Random phases, each under its own gap limit.
    phase_gap[0] = 32'd0;
    phase_gap[1] = 32'hFFFFFFFF;
    phase_gap[2] = $urandom_range(1, 3000);
    phase_gap[3] = $urandom;
    phase_gap[4] = GAP_TIMEOUT_RESET;
    for (int p = 0; p < 5; p++) begin
      set_gap_timeout(phase_gap[p]);
      stamp_now = $urandom;
      target = items_sent + RANDOM_ITEMS / 5;
      while (items_sent < target) run_random_frame();
    end

    // Drain, let the block settle, then report.
    wait_drained();
    repeat (60) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[ale_frame_assembler_unit.f]
rtl/afa_pkg.sv
rtl/afa_ctrl.sv
rtl/afa_datapath.sv
rtl/ale_frame_assembler_unit.sv
tb/tb_ale_frame_assembler_unit.sv
